[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the hasher.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

[hw/rtl/sbsh_pkg.sv]
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Types, constants and round functions shared by the hasher modules.
// ---------------------------------------------------------------------------
package sbsh_pkg;

   typedef enum logic {
      OP_APPEND   = 1'b0,
      OP_FINALIZE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      BSEL_DATA,
      BSEL_PAD,
      BSEL_ZERO,
      BSEL_LEN
   } byte_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic         push;
      byte_sel_type byte_sel;
      logic         latch_len;
      logic         load;
      logic         round;
      logic         fold;
      logic         emit_next;
      logic         restart;
   } sbsh_cmd_type;

   typedef struct packed {
      logic fill_at_56;
      logic fill_at_63;
      logic round_last;
      logic len_last;
      logic out_last;
   } sbsh_status_type;

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [5:0] LEN_OFFSET = 6'd56;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
   endfunction

endpackage

[hw/rtl/sbsh_stream_if.sv]
// ---------------------------------------------------------------------------
// Hasher stream interfaces
// Valid/ready channels for request and digest transactions.
// ---------------------------------------------------------------------------
interface sbsh_req_if;
   logic               valid;
   logic               ready;
   sbsh_pkg::op_type   operation;
   logic [7:0]         data_byte;

   modport source (output valid, output operation, output data_byte, input ready);
   modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface sbsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

[hw/rtl/sbsh_ctrl.sv]
// ---------------------------------------------------------------------------
// Hasher controller
// Sequences byte loads, padding, compression rounds and digest output.
// ---------------------------------------------------------------------------
module sbsh_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  sbsh_pkg::op_type          req_operation,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  sbsh_pkg::sbsh_status_type status,
   output sbsh_pkg::sbsh_cmd_type    cmd
);

   sbsh_pkg::state_type state_ff, state_in;
   logic                fin_ff, fin_in;
   logic                len_phase_ff, len_phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbsh_pkg::ST_IDLE;
         fin_ff       <= 1'b0;
         len_phase_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fin_ff       <= fin_in;
         len_phase_ff <= len_phase_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      fin_in       = fin_ff;
      len_phase_in = len_phase_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd          = '0;
      cmd.byte_sel = sbsh_pkg::BSEL_DATA;
      unique case (state_ff)
         sbsh_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.push = 1'b1;
               if (req_operation == sbsh_pkg::OP_APPEND) begin
                  cmd.byte_sel = sbsh_pkg::BSEL_DATA;
                  fin_in       = 1'b0;
                  if (status.fill_at_63) state_in = sbsh_pkg::ST_LOAD;
               end else begin
                  cmd.byte_sel  = sbsh_pkg::BSEL_PAD;
                  cmd.latch_len = 1'b1;
                  fin_in        = 1'b1;
                  len_phase_in  = 1'b0;
                  state_in      = status.fill_at_63 ? sbsh_pkg::ST_LOAD
                                                    : sbsh_pkg::ST_PAD_ZERO;
               end
            end
         end
         sbsh_pkg::ST_PAD_ZERO: begin
            if (status.fill_at_56) begin
               state_in = sbsh_pkg::ST_PAD_LEN;
            end else begin
               cmd.push     = 1'b1;
               cmd.byte_sel = sbsh_pkg::BSEL_ZERO;
               if (status.fill_at_63) state_in = sbsh_pkg::ST_LOAD;
            end
         end
         sbsh_pkg::ST_PAD_LEN: begin
            cmd.push     = 1'b1;
            cmd.byte_sel = sbsh_pkg::BSEL_LEN;
            len_phase_in = 1'b1;
            if (status.len_last) state_in = sbsh_pkg::ST_LOAD;
         end
         sbsh_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = sbsh_pkg::ST_ROUND;
         end
         sbsh_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
            if (status.round_last) state_in = sbsh_pkg::ST_FOLD;
         end
         sbsh_pkg::ST_FOLD: begin
            cmd.fold = 1'b1;
            if (!fin_ff)          state_in = sbsh_pkg::ST_IDLE;
            else if (len_phase_ff) state_in = sbsh_pkg::ST_EMIT;
            else                  state_in = sbsh_pkg::ST_PAD_ZERO;
         end
         sbsh_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.emit_next = 1'b1;
               if (status.out_last) begin
                  cmd.restart  = 1'b1;
                  fin_in       = 1'b0;
                  len_phase_in = 1'b0;
                  state_in     = sbsh_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sbsh_pkg::ST_IDLE;
      endcase
   end

endmodule

[hw/rtl/sbsh_datapath.sv]
// ---------------------------------------------------------------------------
// Hasher datapath
// Byte packing, message schedule window, round unit and chain hash.
// ---------------------------------------------------------------------------
module sbsh_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [7:0]                req_data_byte,
   input  sbsh_pkg::sbsh_cmd_type    cmd,
   output sbsh_pkg::sbsh_status_type status,
   output logic [31:0]               rsp_digest_word,
   output logic [2:0]                rsp_word_index,
   output logic                      rsp_last_word
);

   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [31:0] vars_ff  [8];
   logic [31:0] vars_in  [8];
   logic [31:0] win_ff   [16];
   logic [31:0] win_in   [16];
   logic [23:0] acc_ff, acc_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [63:0] len_ff, len_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  pad_cnt_ff, pad_cnt_in;
   logic [2:0]  out_idx_ff, out_idx_in;

   logic [7:0]  push_byte;
   logic [31:0] t1, t2, sched_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff   <= sbsh_pkg::INIT_HASH;
         fill_ff    <= '0;
         bits_ff    <= '0;
         round_ff   <= '0;
         pad_cnt_ff <= '0;
         out_idx_ff <= '0;
      end else begin
         chain_ff   <= chain_in;
         fill_ff    <= fill_in;
         bits_ff    <= bits_in;
         round_ff   <= round_in;
         pad_cnt_ff <= pad_cnt_in;
         out_idx_ff <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      vars_ff <= vars_in;
      win_ff  <= win_in;
      acc_ff  <= acc_in;
      len_ff  <= len_in;
   end

   always_comb begin
      unique case (cmd.byte_sel)
         sbsh_pkg::BSEL_DATA: push_byte = req_data_byte;
         sbsh_pkg::BSEL_PAD:  push_byte = sbsh_pkg::PAD_BYTE;
         sbsh_pkg::BSEL_ZERO: push_byte = 8'h00;
         sbsh_pkg::BSEL_LEN:  push_byte = len_ff[63:56];
         default:             push_byte = 8'h00;
      endcase
   end

   assign t1 = vars_ff[7] + sbsh_pkg::big_sigma1(vars_ff[4])
             + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]))
             + sbsh_pkg::ROUND_K[round_ff] + win_ff[0];
   assign t2 = sbsh_pkg::big_sigma0(vars_ff[0])
             + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
                ^ (vars_ff[1] & vars_ff[2]));
   assign sched_word = sbsh_pkg::small_sigma1(win_ff[14]) + win_ff[9]
                     + sbsh_pkg::small_sigma0(win_ff[1]) + win_ff[0];

   always_comb begin
      chain_in   = chain_ff;
      vars_in    = vars_ff;
      win_in     = win_ff;
      acc_in     = acc_ff;
      fill_in    = fill_ff;
      bits_in    = bits_ff;
      len_in     = len_ff;
      round_in   = round_ff;
      pad_cnt_in = pad_cnt_ff;
      out_idx_in = out_idx_ff;

      if (cmd.latch_len) begin
         len_in     = bits_ff;
         pad_cnt_in = '0;
      end
      if (cmd.push) begin
         fill_in = fill_ff + 6'd1;
         bits_in = bits_ff + 64'd8;
         if (fill_ff[1:0] == 2'd3) begin
            for (int i = 0; i < 15; i++) win_in[i] = win_ff[i + 1];
            win_in[15] = {acc_ff, push_byte};
         end else begin
            acc_in = {acc_ff[15:0], push_byte};
         end
         if (cmd.byte_sel == sbsh_pkg::BSEL_LEN) begin
            len_in     = {len_ff[55:0], 8'h00};
            pad_cnt_in = pad_cnt_ff + 3'd1;
         end
      end
      if (cmd.load) begin
         vars_in  = chain_ff;
         round_in = '0;
      end
      if (cmd.round) begin
         vars_in[7] = vars_ff[6];
         vars_in[6] = vars_ff[5];
         vars_in[5] = vars_ff[4];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[3] = vars_ff[2];
         vars_in[2] = vars_ff[1];
         vars_in[1] = vars_ff[0];
         vars_in[0] = t1 + t2;
         for (int i = 0; i < 15; i++) win_in[i] = win_ff[i + 1];
         win_in[15] = sched_word;
         round_in   = round_ff + 6'd1;
      end
      if (cmd.fold) begin
         for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i] + vars_ff[i];
      end
      if (cmd.emit_next) out_idx_in = out_idx_ff + 3'd1;
      if (cmd.restart) begin
         chain_in = sbsh_pkg::INIT_HASH;
         fill_in  = '0;
         bits_in  = '0;
      end
   end

   assign status.fill_at_56 = (fill_ff == sbsh_pkg::LEN_OFFSET);
   assign status.fill_at_63 = (fill_ff == 6'd63);
   assign status.round_last = (round_ff == 6'd63);
   assign status.len_last   = (pad_cnt_ff == 3'd7);
   assign status.out_last   = (out_idx_ff == 3'd7);

   assign rsp_digest_word = chain_ff[out_idx_ff];
   assign rsp_word_index  = out_idx_ff;
   assign rsp_last_word   = (out_idx_ff == 3'd7);

endmodule

[hw/rtl/sha256_byte_stream_hasher.sv]
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a message one byte per transaction and emits the eight digest words.
// ---------------------------------------------------------------------------
// channel   dir   fields
// req_chan  in    operation (1), data_byte (8)
// rsp_chan  out   digest_word (32), word_index (3), last_word (1)
//
// Requests are accepted only while idle; the byte that fills a block runs a
// compression (load, 64 rounds of the single round unit, fold) before the
// next request. Finalize pads one byte per cycle between compressions,
// runs one or two compressions, then holds each digest word until accepted.
// Reset is synchronous and loads the initial hash values; no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sha256_byte_stream_hasher (
   input  logic       clock,
   input  logic       reset,
   sbsh_req_if.sink   req_chan,
   sbsh_rsp_if.source rsp_chan
);

   sbsh_pkg::sbsh_cmd_type    cmd;
   sbsh_pkg::sbsh_status_type status;

   sbsh_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .req_ready     (req_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .status        (status),
      .cmd           (cmd)
   );

   sbsh_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_chan.data_byte),
      .cmd             (cmd),
      .status          (status),
      .rsp_digest_word (rsp_chan.digest_word),
      .rsp_word_index  (rsp_chan.word_index),
      .rsp_last_word   (rsp_chan.last_word)
   );

   `ASSERT_IMP(a_req_not_during_rsp, clock, reset, req_chan.ready, !rsp_chan.valid)
   `ASSERT_IMP(a_round_blocks_req, clock, reset, cmd.round, !req_chan.ready)
   `ASSERT_NEXT(a_last_returns_idle, clock, reset, rsp_chan.valid && rsp_chan.ready && rsp_chan.last_word, req_chan.ready && !rsp_chan.valid)

endmodule

[tb/sbsh_tb_if.sv]
// ---------------------------------------------------------------------------
// Hasher testbench channel interfaces
// The block's own channel interfaces are used; this file holds only the bench's transaction types.
// ---------------------------------------------------------------------------
package sbsh_tb_types_pkg;
   typedef struct {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_beat_type;

   typedef struct {
      sbsh_pkg::op_type operation;
      logic [7:0]       data_byte;
   } hash_req_type;
endpackage

[tb/tb_sha256_byte_stream_hasher.sv]
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Drives append and finalize transactions with random idling on both channels,
// predicts each digest with a local SHA-256 model and checks every digest word.
// ---------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [31:0] H0 [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };
   localparam logic [31:0] KR [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   sbsh_req_if req_chan ();
   sbsh_rsp_if rsp_chan ();

   sha256_byte_stream_hasher i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   logic [31:0]                        model_chain [8];
   logic [7:0]                         model_block [64];
   logic [5:0]                         model_fill;
   logic [63:0]                        model_bits;
   sbsh_tb_types_pkg::hash_req_type    pending_reqs [$];
   sbsh_tb_types_pkg::digest_beat_type digest_words [$];
   int                                 fail_count = 0;
   int                                 cycle_count = 0;
   bit                                 hold_send = 1'b0;
   bit                                 calm = 1'b0;

   function automatic logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic fold_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int r = 0; r < 16; r++)
         w[r] = {model_block[4*r], model_block[4*r+1], model_block[4*r+2], model_block[4*r+3]};
      for (int r = 16; r < 64; r++)
         w[r] = w[r-16] + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3))
              + w[r-7] + (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10));
      for (int i = 0; i < 8; i++) v[i] = model_chain[i];
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KR[r] + w[r];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int i = 7; i > 0; i--) v[i] = v[i-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) model_chain[i] += v[i];
   endtask

   task automatic absorb_byte(logic [7:0] b);
      model_block[model_fill] = b;
      model_fill++;
      model_bits += 64'd8;
      if (model_fill == 6'd0) fold_block();
   endtask

   task automatic restart_message();
      for (int i = 0; i < 8; i++) model_chain[i] = H0[i];
      model_fill = '0;
      model_bits = '0;
   endtask

   task automatic predict_digest(sbsh_tb_types_pkg::hash_req_type t);
      logic [63:0] len;
      sbsh_tb_types_pkg::digest_beat_type d;
      if (t.operation == sbsh_pkg::OP_APPEND) begin
         absorb_byte(t.data_byte);
      end else begin
         len = model_bits;
         absorb_byte(sbsh_pkg::PAD_BYTE);
         while (model_fill != sbsh_pkg::LEN_OFFSET) absorb_byte(8'h00);
         for (int k = 0; k < 8; k++) absorb_byte(len[8*(7-k) +: 8]);
         for (int k = 0; k < 8; k++) begin
            d.digest_word = model_chain[k];
            d.word_index  = k[2:0];
            d.last_word   = (k == 7);
            digest_words.push_back(d);
         end
         restart_message();
      end
   endtask

   function automatic sbsh_tb_types_pkg::hash_req_type mk(sbsh_pkg::op_type op,
                                                           logic [7:0] b);
      sbsh_tb_types_pkg::hash_req_type t;
      t.operation = op;
      t.data_byte = b;
      return t;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid     <= 1'b0;
         req_chan.operation <= sbsh_pkg::OP_APPEND;
         req_chan.data_byte <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_digest(mk(req_chan.operation, req_chan.data_byte));
            void'(pending_reqs.pop_front());
         end
         if (!(req_chan.valid && !req_chan.ready)) begin
            if (pending_reqs.size() > 0 && !hold_send
                && (calm || $urandom_range(99) >= 15)) begin
               req_chan.valid     <= 1'b1;
               req_chan.operation <= pending_reqs[0].operation;
               req_chan.data_byte <= pending_reqs[0].data_byte;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      sbsh_tb_types_pkg::digest_beat_type e;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (digest_words.size() == 0) begin
               $error("digest word with no expectation");
               fail_count++;
            end else begin
               e = digest_words.pop_front();
               if (rsp_chan.digest_word !== e.digest_word) begin
                  $error("digest_word exp %h got %h", e.digest_word, rsp_chan.digest_word);
                  fail_count++;
               end
               if (rsp_chan.word_index !== e.word_index) begin
                  $error("word_index exp %0d got %0d", e.word_index, rsp_chan.word_index);
                  fail_count++;
               end
               if (rsp_chan.last_word !== e.last_word) begin
                  $error("last_word exp %0d got %0d", e.last_word, rsp_chan.last_word);
                  fail_count++;
               end
            end
         end
         rsp_chan.ready <= calm || ($urandom_range(99) >= 15);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic queue_message(int n, bit rnd);
      for (int i = 0; i < n; i++)
         pending_reqs.push_back(mk(sbsh_pkg::OP_APPEND, rnd ? 8'($urandom) : 8'(i)));
      pending_reqs.push_back(mk(sbsh_pkg::OP_FINALIZE, 8'($urandom)));
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_chan.valid || digest_words.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int lens [4];
      restart_message();
      for (int i = 0; i < 64; i++) model_block[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // directed: empty, double finalize, byte extremes, finalize with junk byte
      pending_reqs.push_back(mk(sbsh_pkg::OP_FINALIZE, 8'h00));
      pending_reqs.push_back(mk(sbsh_pkg::OP_FINALIZE, 8'hff));
      pending_reqs.push_back(mk(sbsh_pkg::OP_APPEND, 8'h00));
      pending_reqs.push_back(mk(sbsh_pkg::OP_APPEND, 8'hff));
      pending_reqs.push_back(mk(sbsh_pkg::OP_APPEND, 8'h80));
      pending_reqs.push_back(mk(sbsh_pkg::OP_APPEND, 8'h7f));
      pending_reqs.push_back(mk(sbsh_pkg::OP_FINALIZE, 8'h55));
      pending_reqs.push_back(mk(sbsh_pkg::OP_APPEND, 8'haa));
      pending_reqs.push_back(mk(sbsh_pkg::OP_FINALIZE, 8'haa));
      drain();
      // pause the sender once the digests are out
      hold_send = 1'b1;
      repeat (20) @(posedge clock);
      hold_send = 1'b0;
      // full block on append, then short messages
      lens = '{64, 3, 0, 1};
      calm = 1'b1;
      queue_message(lens[0], 1);
      drain();
      calm = 1'b0;
      for (int i = 1; i < 4; i++) queue_message(lens[i], 1);
      drain();
      for (int m = 0; m < 6; m++) queue_message($urandom_range(8), 1);
      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && digest_words.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/sbsh_pkg.sv
hw/rtl/sbsh_stream_if.sv
hw/rtl/sbsh_ctrl.sv
hw/rtl/sbsh_datapath.sv
hw/rtl/sha256_byte_stream_hasher.sv
tb/sbsh_tb_if.sv
tb/tb_sha256_byte_stream_hasher.sv
